// ===== src/b64e_pkg.sv =====
package b64e_pkg;

   localparam int B64E_QUEUE_DEPTH = 2;

   localparam logic [7:0] B64E_PAD_CHAR = 8'h3D;

   localparam logic [0:63][7:0] B64E_ALPHABET =
      "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/";

   typedef enum logic [1:0] {
      PHASE_0 = 2'd0,
      PHASE_1 = 2'd1,
      PHASE_2 = 2'd2
   } b64e_phase_type;

   // One accepted byte turns into up to four characters; last_idx is the
   // index of the final character in the set.
   typedef struct packed {
      logic [3:0][7:0] chars;
      logic [1:0]      last_idx;
      logic            eom;
   } b64e_job_type;

   typedef struct packed {
      logic         valid;
      b64e_job_type job;
   } b64e_q_out_type;

   function automatic logic [7:0] b64e_sym_char(input logic [5:0] sym);
      return B64E_ALPHABET[sym];
   endfunction

endpackage

// ===== src/b64e_front.sv =====
module b64e_front (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   input  logic [7:0]            req_data_byte,
   input  logic                  req_end_of_message,
   input  logic                  queue_full,
   output logic                  req_stall,
   output logic                  push,
   output b64e_pkg::b64e_job_type push_job
);
   import b64e_pkg::*;

   b64e_phase_type phase_ff, phase_in;
   logic [3:0]     carry_ff, carry_in;
   logic           accept;

   assign req_stall = queue_full;
   assign accept    = req_valid && !queue_full;
   assign push      = accept;

   always_comb begin
      push_job.chars    = {4{B64E_PAD_CHAR}};
      push_job.last_idx = 2'd0;
      push_job.eom      = req_end_of_message;
      phase_in          = phase_ff;
      carry_in          = carry_ff;
      unique case (phase_ff)
         PHASE_1: begin
            push_job.chars[0] = b64e_sym_char({carry_ff[1:0], req_data_byte[7:4]});
            if (req_end_of_message) begin
               push_job.chars[1] = b64e_sym_char({req_data_byte[3:0], 2'b00});
               push_job.last_idx = 2'd2;
            end
            phase_in = PHASE_2;
            carry_in = req_data_byte[3:0];
         end
         PHASE_2: begin
            push_job.chars[0] = b64e_sym_char({carry_ff, req_data_byte[7:6]});
            push_job.chars[1] = b64e_sym_char(req_data_byte[5:0]);
            push_job.last_idx = 2'd1;
            phase_in          = PHASE_0;
            carry_in          = 4'd0;
         end
         default: begin
            // The unused phase code behaves like the start of a group.
            push_job.chars[0] = b64e_sym_char(req_data_byte[7:2]);
            if (req_end_of_message) begin
               push_job.chars[1] = b64e_sym_char({req_data_byte[1:0], 4'b0000});
               push_job.last_idx = 2'd3;
            end
            phase_in = PHASE_1;
            carry_in = {2'b00, req_data_byte[1:0]};
         end
      endcase
      if (req_end_of_message) begin
         phase_in = PHASE_0;
         carry_in = 4'd0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PHASE_0;
         carry_ff <= 4'd0;
      end else if (accept) begin
         phase_ff <= phase_in;
         carry_ff <= carry_in;
      end
   end

endmodule

// ===== src/b64e_queue.sv =====
module b64e_queue #(
   parameter int DEPTH = b64e_pkg::B64E_QUEUE_DEPTH
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    push,
   input  b64e_pkg::b64e_job_type  push_job,
   input  logic                    pop,
   output logic                    full,
   output b64e_pkg::b64e_q_out_type head
);
   import b64e_pkg::*;

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
   localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

   b64e_job_type     slots_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;

   assign full       = (count_ff == FULL_CNT);
   assign head.valid = (count_ff != '0);
   assign head.job   = slots_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == LAST_PTR) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST_PTR) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slots_ff[wr_ptr_ff] <= push_job;
      end
   end

endmodule

// ===== src/b64e_back.sv =====
module b64e_back (
   input  logic                     clock,
   input  logic                     reset,
   input  b64e_pkg::b64e_q_out_type head,
   output logic                     pop,
   output logic                     rsp_valid,
   input  logic                     rsp_stall,
   output logic [7:0]               rsp_out_char,
   output logic                     rsp_last_char
);
   import b64e_pkg::*;

   logic [1:0] idx_ff, idx_in;
   logic       valid_ff, valid_in;
   logic [7:0] char_ff;
   logic       last_ff;
   logic       load;
   logic       final_of_job;

   assign load         = head.valid && (!valid_ff || !rsp_stall);
   assign final_of_job = (idx_ff == head.job.last_idx);
   assign pop          = load && final_of_job;

   always_comb begin
      idx_in   = idx_ff;
      valid_in = valid_ff;
      if (load) begin
         valid_in = 1'b1;
         idx_in   = final_of_job ? 2'd0 : idx_ff + 2'd1;
      end else if (!rsp_stall) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff   <= 2'd0;
         valid_ff <= 1'b0;
      end else begin
         idx_ff   <= idx_in;
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         char_ff <= head.job.chars[idx_ff];
         last_ff <= head.job.eom && final_of_job;
      end
   end

   assign rsp_valid     = valid_ff;
   assign rsp_out_char  = char_ff;
   assign rsp_last_char = last_ff;

endmodule

// ===== src/base64_stream_encoder.sv =====
// A character passes through the job queue, then the output register, to the rsp side.
// Throughput: one character per cycle at the registered output unless stalled; a byte
// gives one or two characters (three or four if it ends a partial group), four per group.
// The output register and the job queue, two entries by default, set that rate.
// Reset is synchronous and clears group phase, carry bits, queue and output valid.
module base64_stream_encoder #(
   parameter int QUEUE_DEPTH = b64e_pkg::B64E_QUEUE_DEPTH
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [7:0] req_data_byte,
   input  logic       req_end_of_message,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic [7:0] rsp_out_char,
   output logic       rsp_last_char
);
   import b64e_pkg::*;

   logic           push;
   logic           pop;
   logic           queue_full;
   b64e_job_type   push_job;
   b64e_q_out_type head;

   b64e_front u_front (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_data_byte      (req_data_byte),
      .req_end_of_message (req_end_of_message),
      .queue_full         (queue_full),
      .req_stall          (req_stall),
      .push               (push),
      .push_job           (push_job)
   );

   b64e_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_job (push_job),
      .pop      (pop),
      .full     (queue_full),
      .head     (head)
   );

   b64e_back u_back (
      .clock         (clock),
      .reset         (reset),
      .head          (head),
      .pop           (pop),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_out_char  (rsp_out_char),
      .rsp_last_char (rsp_last_char)
   );

endmodule

// ===== src/b64e_checker.sv =====
module b64e_checker (
   input logic       clock,
   input logic       reset,
   input logic       req_valid,
   input logic       req_stall,
   input logic [7:0] req_data_byte,
   input logic       req_end_of_message,
   input logic       rsp_valid,
   input logic       rsp_stall,
   input logic [7:0] rsp_out_char,
   input logic       rsp_last_char
);
   import b64e_pkg::*;

   // Nothing is shown on the output right after a reset.
   a_reset_clears: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("rsp_valid high after reset");

   a_valid_holds: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid)
      else $error("rsp_valid dropped while stalled");

   // A stalled input beat stays on the lines unchanged until it is taken.
   a_req_holds: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_stall |=>
         req_valid && $stable(req_data_byte) && $stable(req_end_of_message))
      else $error("input beat changed while stalled");

   // A padding character that does not end the message is always the first of
   // two, and the second one is already queued behind it.
   a_pad_pair: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_stall && (rsp_out_char == B64E_PAD_CHAR) && !rsp_last_char
      |=> rsp_valid && (rsp_out_char == B64E_PAD_CHAR) && rsp_last_char)
      else $error("first padding character not followed by final padding");

   // The last character of a message is either padding or a symbol character.
   a_last_is_b64: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_last_char |->
         (rsp_out_char == B64E_PAD_CHAR) ||
         ((rsp_out_char >= 8'h41) && (rsp_out_char <= 8'h5A)) ||
         ((rsp_out_char >= 8'h61) && (rsp_out_char <= 8'h7A)) ||
         ((rsp_out_char >= 8'h30) && (rsp_out_char <= 8'h39)) ||
         (rsp_out_char == 8'h2B) || (rsp_out_char == 8'h2F))
      else $error("final character outside the base64 set");

endmodule

bind base64_stream_encoder b64e_checker u_checker (.*);

// ===== verif/tb_base64_stream_encoder.sv =====
module tb_base64_stream_encoder;
   timeunit 1ns;
   timeprecision 1ps;

   import b64e_pkg::*;

   localparam int IDLE_LIMIT = 2000;
   localparam int TAIL_CYCLES = 10;
   localparam int RANDOM_ITEMS = 80;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       eom;
   } byte_beat_type;

   typedef struct packed {
      logic [7:0] ch;
      logic       last;
   } char_beat_type;

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       req_valid = 1'b0;
   logic       req_stall;
   logic [7:0] req_data_byte = 8'h00;
   logic       req_end_of_message = 1'b0;
   logic       rsp_valid;
   logic       rsp_stall = 1'b1;
   logic [7:0] rsp_out_char;
   logic       rsp_last_char;

   byte_beat_type pending_bytes[$];
   char_beat_type expected_chars[$];

   b64e_phase_type enc_phase = PHASE_0;
   logic [3:0]     enc_carry = 4'h0;

   int mismatch_count = 0;
   int idle_cycles = 0;
   int send_wait = 0;
   int send_burst = 0;
   int recv_wait = 0;
   int recv_burst = 0;

   base64_stream_encoder uut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_data_byte      (req_data_byte),
      .req_end_of_message (req_end_of_message),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_out_char       (rsp_out_char),
      .rsp_last_char      (rsp_last_char)
   );

   always #2 clock = ~clock;

   // Mostly random gaps, with occasional stretches where the side never idles.
   function automatic int draw_gap(inout int burst);
      if (burst > 0) begin
         burst--;
         return 0;
      end
      if ($urandom_range(0, 9) == 0) begin
         burst = $urandom_range(5, 20);
         return 0;
      end
      return $urandom_range(0, 13);
   endfunction

   function automatic logic [7:0] symbol_ascii(input logic [5:0] s);
      if (s < 26) return "A" + s;
      if (s < 52) return "a" + s - 8'd26;
      if (s < 62) return "0" + s - 8'd52;
      if (s == 62) return "+";
      return "/";
   endfunction

   function automatic void push_char(input logic [5:0] s, input logic last);
      expected_chars.push_back('{ch: symbol_ascii(s), last: last});
   endfunction

   function automatic void push_pad(input logic last);
      expected_chars.push_back('{ch: "=", last: last});
   endfunction

   function automatic void encode_byte(input logic [7:0] b, input logic eom);
      case (enc_phase)
         PHASE_1: begin
            push_char({enc_carry[1:0], b[7:4]}, 1'b0);
            if (eom) begin
               push_char({b[3:0], 2'b00}, 1'b0);
               push_pad(1'b1);
            end else begin
               enc_carry = b[3:0];
               enc_phase = PHASE_2;
            end
         end
         PHASE_2: begin
            push_char({enc_carry, b[7:6]}, 1'b0);
            push_char(b[5:0], eom);
            enc_carry = 4'h0;
            enc_phase = PHASE_0;
         end
         default: begin
            push_char(b[7:2], 1'b0);
            if (eom) begin
               push_char({b[1:0], 4'h0}, 1'b0);
               push_pad(1'b0);
               push_pad(1'b1);
            end else begin
               enc_carry = {2'b00, b[1:0]};
               enc_phase = PHASE_1;
            end
         end
      endcase
      if (eom) begin
         enc_phase = PHASE_0;
         enc_carry = 4'h0;
      end
   endfunction

   task automatic report_mismatch(input string msg);
      $display("[%0t] mismatch: %s", $realtime, msg);
      mismatch_count++;
   endtask

   task automatic add_byte(input logic [7:0] b, input logic eom);
      pending_bytes.push_back('{data_byte: b, eom: eom});
   endtask

   task automatic add_message(input int len);
      for (int i = 0; i < len; i++) begin
         add_byte(8'($urandom_range(0, 255)), i == len - 1);
      end
   endtask

   // Byte driver: a new beat is loaded only when the line is free or the
   // current beat is taken, so the payload holds while stalled.
   always @(posedge clock) begin
      byte_beat_type item;
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && !req_stall) begin
            encode_byte(req_data_byte, req_end_of_message);
         end
         if (!req_valid || !req_stall) begin
            if (send_wait > 0) begin
               send_wait--;
               req_valid <= 1'b0;
            end else if (pending_bytes.size() > 0) begin
               item = pending_bytes.pop_front();
               req_valid <= 1'b1;
               req_data_byte <= item.data_byte;
               req_end_of_message <= item.eom;
               send_wait = draw_gap(send_burst);
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // Character monitor and stall generator.
   always @(posedge clock) begin
      char_beat_type exp_beat;
      if (!reset) begin
         if (rsp_valid && !rsp_stall) begin
            if (expected_chars.size() == 0) begin
               report_mismatch($sformatf("unexpected char 8'h%02h last=%0b",
                                         rsp_out_char, rsp_last_char));
            end else begin
               exp_beat = expected_chars.pop_front();
               if (rsp_out_char !== exp_beat.ch)
                  report_mismatch($sformatf("out_char 8'h%02h, expected 8'h%02h",
                                            rsp_out_char, exp_beat.ch));
               if (rsp_last_char !== exp_beat.last)
                  report_mismatch($sformatf("last_char %0b, expected %0b on 8'h%02h",
                                            rsp_last_char, exp_beat.last, exp_beat.ch));
            end
            recv_wait = draw_gap(recv_burst);
         end
         if (recv_wait > 0) begin
            recv_wait--;
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         idle_cycles = 0;
      end else begin
         idle_cycles++;
      end
      if (idle_cycles >= IDLE_LIMIT) begin
         $display("base64_stream_encoder verification failed");
         $finish;
      end
   end

   initial begin
      int queued;
      // Messages ending in each group position, with the byte extremes.
      add_byte(8'h00, 1'b1);
      add_byte(8'hFF, 1'b1);
      add_byte(8'h00, 1'b0);
      add_byte(8'hFF, 1'b1);
      add_byte(8'hFF, 1'b0);
      add_byte(8'h00, 1'b1);
      add_byte(8'hFF, 1'b0);
      add_byte(8'hFF, 1'b0);
      add_byte(8'hFF, 1'b1);
      add_byte(8'h00, 1'b0);
      add_byte(8'h00, 1'b0);
      add_byte(8'h00, 1'b1);
      // A message spanning two groups and ending one byte into the third.
      add_byte(8'hAA, 1'b0);
      add_byte(8'h55, 1'b0);
      add_byte(8'hAA, 1'b0);
      add_byte(8'h55, 1'b0);
      add_byte(8'hFB, 1'b0);
      add_byte(8'hEF, 1'b0);
      add_byte(8'hBE, 1'b1);
      // The final byte lands in the middle of a group.
      add_byte(8'h3E, 1'b0);
      add_byte(8'h3F, 1'b1);

      queued = 0;
      while (queued < RANDOM_ITEMS) begin
         int len;
         len = ($urandom_range(0, 7) == 0) ? $urandom_range(10, 20) : $urandom_range(1, 7);
         add_message(len);
         queued += len;
      end

      repeat (2) @(posedge clock);
      reset <= 1'b0;

      do begin
         @(negedge clock);
      end while (pending_bytes.size() != 0 || req_valid || expected_chars.size() != 0);
      repeat (TAIL_CYCLES) @(posedge clock);

      if (mismatch_count == 0) begin
         $display("base64_stream_encoder verification clean");
      end else begin
         $display("base64_stream_encoder verification failed");
      end
      $finish;
   end

endmodule
